### rtl/wsr_pkg.sv
// Package for the weighted softmax row block: shared types and constants.
// No dependencies.
package wsr_pkg;

    localparam logic [31:0] EXP_NEG_ONE_Q32 = 32'd1580030169;
    localparam logic [32:0] ONE_Q32 = 33'h1_0000_0000;
    localparam int SERIES_TERMS = 13;

    localparam logic [1:0] STATUS_OK = 2'd0;
    localparam logic [1:0] STATUS_ZERO = 2'd1;
    localparam logic [1:0] STATUS_OVFL = 2'd2;

    // controller to datapath commands
    typedef struct packed {
        logic store;       // write incoming item into the row buffer
        logic clr_row;     // reset count, max and overflow flag
        logic clr_sum;     // clear the running sum
        logic ld_item;     // load gap of item at walk index
        logic ser_start;   // start divide of one series term
        logic ser_step;    // three quotient bits of a series term
        logic ser_done;    // clamp series result
        logic pow_step;    // one multiply by exp(-1)
        logic val_mul;     // form weighted value, add to sum
        logic div_start;   // start share division
        logic div_step;    // one quotient bit
        logic idx_clr;     // clear walk index
        logic idx_inc;     // advance walk index
    } wsr_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic ser_last;    // last series term reached
        logic tdiv_last;   // last quotient group of a series term
        logic pow_more;    // integer exponent still pending
        logic big_gap;     // gap of 32 or more: exp is zero
        logic walk_last;   // walk index at final stored item
        logic row_empty;   // no stored items
        logic div_last;    // last quotient bit
        logic sum_zero;    // total is zero
    } wsr_sts_t;

endpackage

### rtl/wsr_datapath.sv
// Datapath of the weighted softmax row block: row buffer, exp unit,
// value store, sum and bit-serial divider. Depends on wsr_pkg.
module wsr_datapath #(
    parameter int MAX_PARTS = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  wsr_pkg::wsr_cmd_t cmd,
    output wsr_pkg::wsr_sts_t sts,
    input  logic [31:0]       in_score,
    input  logic [16:0]       in_weight,
    output logic [16:0]       share,
    output logic [5:0]        part_index,
    output logic [1:0]        status,
    output logic              run_end
);
    localparam int IW = $clog2(MAX_PARTS);
    localparam int CW = $clog2(MAX_PARTS + 1);

    // row buffer memories
    logic [31:0] score_mem [MAX_PARTS];
    logic [16:0] weight_mem [MAX_PARTS];
    logic [48:0] val_mem [MAX_PARTS];

    logic [CW-1:0] count_reg, count_next;
    logic signed [31:0] max_reg, max_next;
    logic ovf_reg, ovf_next;
    logic [IW-1:0] idx_reg;
    logic [31:0] rd_score_reg;
    logic [16:0] rd_weight_reg;
    logic [48:0] rd_val_reg;

    // exp unit registers
    logic [15:0] fp_reg;
    logic [15:0] ip_reg;
    logic        big_reg;
    logic [32:0] term_reg;
    logic signed [35:0] acc_reg;
    logic [32:0] e_reg;
    logic [3:0]  k_reg;
    logic [32:0] dvd_reg;      // term divider: dividend in, quotient out
    logic [3:0]  trem_reg;     // term divider remainder
    logic [3:0]  tgrp_reg;     // quotient groups left

    // sum and divider
    logic [52:0] sum_reg;
    logic [69:0] rem_reg;
    logic [16:0] q_reg;
    logic [4:0]  dbit_reg;
    logic [69:0] den_reg;

    // row bookkeeping
    always_comb
    begin
        count_next = count_reg;
        max_next = max_reg;
        ovf_next = ovf_reg;
        if (cmd.clr_row)
        begin
            count_next = '0;
            max_next = 32'sh8000_0000;
            ovf_next = 1'b0;
        end
        else if (cmd.store)
        begin
            if (count_reg < CW'(MAX_PARTS))
            begin
                count_next = count_reg + CW'(1);
                if ($signed(in_score) > max_reg)
                    max_next = $signed(in_score);
            end
            else
                ovf_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            max_reg <= 32'sh8000_0000;
            ovf_reg <= 1'b0;
            idx_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
            max_reg <= max_next;
            ovf_reg <= ovf_next;
            if (cmd.idx_clr)
                idx_reg <= '0;
            else if (cmd.idx_inc)
                idx_reg <= idx_reg + IW'(1);
        end
    end

    // memory ports
    always_ff @(posedge clk)
    begin
        if (cmd.store && count_reg < CW'(MAX_PARTS))
        begin
            score_mem[count_reg[IW-1:0]] <= in_score;
            weight_mem[count_reg[IW-1:0]] <= in_weight;
        end
        if (cmd.val_mul)
            val_mem[idx_reg] <= 49'(({32'd0, rd_weight_reg} * {16'd0, e_reg}) >> 16);
        rd_score_reg <= score_mem[idx_reg];
        rd_weight_reg <= weight_mem[idx_reg];
        rd_val_reg <= val_mem[idx_reg];
    end

    // exp unit: series then integer power
    logic [32:0] gap;
    logic [48:0] tprod;
    logic [32:0] tdiv;
    logic [3:0]  trem_next;
    logic [4:0]  tpart;
    logic [64:0] pprod;
    always_comb
    begin
        gap = 33'({max_reg[31], max_reg} - {rd_score_reg[31], rd_score_reg});
        tprod = 49'(({16'd0, term_reg} * {33'd0, fp_reg}) >> 16);
        // term / k, three quotient bits per cycle
        tdiv = dvd_reg;
        trem_next = trem_reg;
        tpart = '0;
        for (int b = 0; b < 3; b++)
        begin
            tpart = {trem_next, tdiv[32]};
            tdiv = {tdiv[31:0], 1'b0};
            if (tpart >= {1'b0, k_reg})
            begin
                trem_next = 4'(tpart - {1'b0, k_reg});
                tdiv[0] = 1'b1;
            end
            else
                trem_next = tpart[3:0];
        end
        pprod = 65'({32'd0, e_reg} * {33'd0, wsr_pkg::EXP_NEG_ONE_Q32});
    end

    always_ff @(posedge clk)
    begin
        if (cmd.ld_item)
        begin
            fp_reg <= gap[15:0];
            ip_reg <= {15'd0, 1'b0} | 16'(gap[32:16]);
            big_reg <= gap[32:16] >= 17'd32;
            term_reg <= wsr_pkg::ONE_Q32;
            acc_reg <= 36'sh1_0000_0000;
            k_reg <= 4'd1;
        end
        else if (cmd.ser_start)
        begin
            dvd_reg <= tprod[32:0];
            trem_reg <= '0;
            tgrp_reg <= 4'd10;     // 11 groups of 3 bits
        end
        else if (cmd.ser_step)
        begin
            dvd_reg <= tdiv;
            trem_reg <= trem_next;
            tgrp_reg <= tgrp_reg - 4'd1;
            if (tgrp_reg == 4'd0)
            begin
                term_reg <= tdiv;
                if (k_reg[0])
                    acc_reg <= acc_reg - $signed({3'd0, tdiv});
                else
                    acc_reg <= acc_reg + $signed({3'd0, tdiv});
                k_reg <= k_reg + 4'd1;
            end
        end
        else if (cmd.ser_done)
        begin
            if (big_reg)
                e_reg <= '0;
            else if (acc_reg < 0)
                e_reg <= '0;
            else if (acc_reg > 36'sh1_0000_0000)
                e_reg <= wsr_pkg::ONE_Q32;
            else
                e_reg <= acc_reg[32:0];
        end
        else if (cmd.pow_step)
        begin
            e_reg <= 33'((pprod + 65'h8000_0000) >> 32);
            ip_reg <= ip_reg - 16'd1;
        end
    end

    // sum and restoring divider, one quotient bit per cycle
    always_ff @(posedge clk)
    begin
        if (cmd.clr_sum)
            sum_reg <= '0;
        else if (cmd.val_mul)
            sum_reg <= sum_reg + 53'(({32'd0, rd_weight_reg} * {16'd0, e_reg}) >> 16);
        if (cmd.div_start)
        begin
            rem_reg <= 70'({rd_val_reg, 16'd0}) + 70'(sum_reg >> 1);
            den_reg <= 70'(sum_reg) << 16;
            q_reg <= '0;
            dbit_reg <= 5'd16;
        end
        else if (cmd.div_step)
        begin
            if (rem_reg >= den_reg)
            begin
                rem_reg <= rem_reg - den_reg;
                q_reg <= q_reg | (17'd1 << dbit_reg);
            end
            den_reg <= den_reg >> 1;
            dbit_reg <= dbit_reg - 5'd1;
        end
    end

    always_comb
    begin
        sts.ser_last = (k_reg == 4'(wsr_pkg::SERIES_TERMS));
        sts.tdiv_last = (tgrp_reg == 4'd0);
        sts.pow_more = (ip_reg != 16'd0) && !big_reg;
        sts.big_gap = big_reg;
        sts.walk_last = (CW'(idx_reg) + CW'(1) >= count_reg);
        sts.row_empty = (count_reg == '0);
        sts.div_last = (dbit_reg == 5'd0);
        sts.sum_zero = (sum_reg == '0);
        share = sts.sum_zero ? 17'd0 : q_reg;
        part_index = 6'(idx_reg);
        status = sts.sum_zero ? wsr_pkg::STATUS_ZERO
               : (ovf_reg ? wsr_pkg::STATUS_OVFL : wsr_pkg::STATUS_OK);
        run_end = sts.walk_last;
    end

endmodule

### rtl/wsr_ctrl.sv
// Controller of the weighted softmax row block: sequences load, exp walk,
// division walk and output. Depends on wsr_pkg.
module wsr_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_fire,
    input  logic              in_last,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    output wsr_pkg::wsr_cmd_t cmd,
    input  wsr_pkg::wsr_sts_t sts
);
    typedef enum logic [10:0] {
        S_LOAD  = 11'b000_0000_0001,
        S_RD    = 11'b000_0000_0010,
        S_GAP   = 11'b000_0000_0100,
        S_SER   = 11'b000_0000_1000,
        S_TDV   = 11'b000_0001_0000,
        S_POW   = 11'b000_0010_0000,
        S_VAL   = 11'b000_0100_0000,
        S_DRD   = 11'b000_1000_0000,
        S_DST   = 11'b001_0000_0000,
        S_DIV   = 11'b010_0000_0000,
        S_OUT   = 11'b100_0000_0000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_LOAD;
        else
            state_reg <= state_next;
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        in_ready = 1'b0;
        out_valid = 1'b0;
        unique case (state_reg)
            S_LOAD:
            begin
                in_ready = 1'b1;
                if (in_fire)
                begin
                    cmd.store = 1'b1;
                    if (in_last)
                    begin
                        cmd.idx_clr = 1'b1;
                        cmd.clr_sum = 1'b1;
                        state_next = S_RD;
                    end
                end
            end
            S_RD:
                state_next = sts.row_empty ? S_LOAD : S_GAP;
            S_GAP:
            begin
                cmd.ld_item = 1'b1;
                state_next = S_SER;
            end
            S_SER:
            begin
                cmd.ser_start = 1'b1;
                state_next = S_TDV;
            end
            S_TDV:
            begin
                cmd.ser_step = 1'b1;
                if (sts.tdiv_last)
                    state_next = sts.ser_last ? S_POW : S_SER;
            end
            S_POW:
            begin
                cmd.ser_done = 1'b1;
                state_next = S_VAL;
            end
            S_VAL:
            begin
                if (sts.pow_more)
                    cmd.pow_step = 1'b1;
                else
                begin
                    cmd.val_mul = 1'b1;
                    if (sts.walk_last)
                    begin
                        cmd.idx_clr = 1'b1;
                        state_next = S_DRD;
                    end
                    else
                    begin
                        cmd.idx_inc = 1'b1;
                        state_next = S_RD;
                    end
                end
            end
            S_DRD:
                state_next = S_DST;
            S_DST:
            begin
                cmd.div_start = 1'b1;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_last)
                    state_next = S_OUT;
            end
            S_OUT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    if (sts.walk_last)
                    begin
                        cmd.clr_row = 1'b1;
                        state_next = S_LOAD;
                    end
                    else
                    begin
                        cmd.idx_inc = 1'b1;
                        state_next = S_DRD;
                    end
                end
            end
            default:
                state_next = S_LOAD;
        endcase
        if (state_reg == S_RD && sts.row_empty)
            cmd.clr_row = 1'b1;
    end

endmodule

### rtl/weighted_softmax_row.sv
// Top level of the weighted softmax row block.
// Depends on wsr_pkg, wsr_ctrl and wsr_datapath.
//
// Usage: a row of items arrives on s_axis; tdata holds score (bits 31:0)
// and weight (48:32), tlast marks the row end. Items are buffered (one per
// cycle while loading) up to MAX_PARTS; further items are dropped and
// flagged. After the last item the row is walked once to form
// w*exp(s-max): 13 series terms (the divide by the term number gives three
// bits a cycle) and up to 31 multiplies by exp(-1) per item. The row is
// walked again with a bit-serial divider: the first share follows the exp
// walk and each later one the previous transfer, plus the wait for
// m_axis_tready. Shares leave on m_axis in order, tdata = share (16:0),
// part_index (22:17), status (24:23), with tlast on the final share.
// Input is not accepted while a row is being computed or emitted. A
// stalled receiver simply holds the current share. Reset clears the item
// count, maximum and flags; buffer contents need no clearing. A row end
// that finds no stored item produces no output.
module weighted_softmax_row #(
    parameter int MAX_PARTS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [55:0] s_axis_tdata,   // score[31:0], weight[48:32], zero pad
    input  logic        s_axis_tlast,   // row_end
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // share[16:0], part_index[22:17], status[24:23]
    output logic        m_axis_tlast    // run_end
);
    wsr_pkg::wsr_cmd_t cmd;
    wsr_pkg::wsr_sts_t sts;
    logic [16:0] share;
    logic [5:0]  part_index;
    logic [1:0]  status;
    logic        in_fire;

    assign in_fire = s_axis_tvalid && s_axis_tready;

    wsr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_fire   (in_fire),
        .in_last   (s_axis_tlast),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .cmd       (cmd),
        .sts       (sts)
    );

    wsr_datapath #(
        .MAX_PARTS (MAX_PARTS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .in_score   (s_axis_tdata[31:0]),
        .in_weight  (s_axis_tdata[48:32]),
        .share      (share),
        .part_index (part_index),
        .status     (status),
        .run_end    (m_axis_tlast)
    );

    assign m_axis_tdata = {7'd0, status, part_index, share};

endmodule
